// ===== design/tvs_pkg.sv =====
// Shared types and constants for the trilinear voxel sampler.
package tvs_pkg;

    localparam int STORE_AW     = 15;
    localparam int STORE_DEPTH  = 1 << STORE_AW;
    localparam int VAL_W        = 16;
    localparam int COORD_W      = 16;
    localparam int DIM_REG_W    = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CORNERS      = 8;
    localparam int CORNER_W     = 3;
    localparam int MAX_DIM_DEF  = 32;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = DIM_REG_W'(32);

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_ROW,
        S_PLANE,
        S_READ,
        S_DRAIN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic                capture;
        logic                store;
        logic                clamp;
        logic                row;
        logic                plane;
        logic                rd_en;
        logic [CORNER_W-1:0] rd_idx;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic out_full;
    } t_sts;

endpackage

// ===== design/tvs_ctrl.sv =====
// Sequencer for the trilinear voxel sampler: accept, setup, corner reads, result hand-off.
module tvs_ctrl
    import tvs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_mode,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    t_state              r_state;
    t_state              n_state;
    logic [CORNER_W-1:0] r_cnt;
    logic [CORNER_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_mode) n_state = S_CLAMP;
            end
            S_CLAMP: n_state = S_ROW;
            S_ROW:   n_state = S_PLANE;
            S_PLANE: n_state = S_READ;
            S_READ: begin
                n_cnt = r_cnt + CORNER_W'(1);
                if (r_cnt == CORNER_W'(CORNERS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (i_sts.done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid && i_mode;
                o_cmd.store   = i_in_valid && !i_mode;
            end
            S_CLAMP: o_cmd.clamp = 1'b1;
            S_ROW:   o_cmd.row   = 1'b1;
            S_PLANE: o_cmd.plane = 1'b1;
            S_READ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_idx = r_cnt;
            end
            S_DRAIN: o_cmd.load_out = 1'b0;
            S_FIN:   o_cmd.load_out = !i_sts.out_full;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

// ===== design/tvs_dp.sv =====
// Datapath: dimension registers, voxel memory, corner addressing and the three lerp stages.
module tvs_dp
    import tvs_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic                       i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [DIM_REG_W-1:0]       i_cfg_data,
    input  logic [STORE_AW-1:0]        i_voxel_index,
    input  logic signed [VAL_W-1:0]    i_voxel_value,
    input  logic signed [COORD_W-1:0]  i_coord_x,
    input  logic signed [COORD_W-1:0]  i_coord_y,
    input  logic signed [COORD_W-1:0]  i_coord_z,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [VAL_W-1:0]    o_sample_value
);

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = COORD_W + 2;
    localparam int RW = IW + DW;
    localparam int PW = IW + 2 * DW;

    function automatic logic [DW-1:0] f_eff(input logic [DIM_REG_W-1:0] d);
        if (d == '0) return DW'(1);
        if (32'(d) > 32'(MAX_DIM)) return DW'(MAX_DIM);
        return DW'(d);
    endfunction

    function automatic logic [IW-1:0] f_clamp(input logic signed [CW-1:0] v,
                                              input logic [DW-1:0] d);
        logic signed [CW-1:0] hi;
        hi = $signed(CW'(d) - CW'(1));
        if (v < 0) return '0;
        if (v > hi) return IW'(hi);
        return IW'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] f_lerp(
        input logic signed [VAL_W-1:0]  a,
        input logic signed [VAL_W-1:0]  b,
        input logic [FRAC_BITS-1:0]     t
    );
        logic signed [VAL_W:0]             d;
        logic signed [VAL_W+FRAC_BITS+1:0] p;
        logic signed [VAL_W+FRAC_BITS+1:0] s;
        d = $signed({b[VAL_W-1], b}) - $signed({a[VAL_W-1], a});
        p = d * $signed({1'b0, t});
        s = (VAL_W+FRAC_BITS+2)'(a) + (p >>> FRAC_BITS);
        return s[VAL_W-1:0];
    endfunction

    logic [DIM_REG_W-1:0] r_dim_x;
    logic [DIM_REG_W-1:0] r_dim_y;
    logic [DIM_REG_W-1:0] r_dim_z;

    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [COORD_W-1:0] r_cz;
    logic [DW-1:0]             r_dx;
    logic [DW-1:0]             r_dy;
    logic [IW-1:0]             r_x0, r_x1, r_y0, r_y1, r_z0, r_z1;
    logic [2*DW-1:0]           r_dxy;
    logic [RW-1:0]             r_y0dx, r_y1dx;
    logic [PW-1:0]             r_z0o, r_z1o;

    logic [VAL_W-1:0]          r_mem [STORE_DEPTH];
    logic signed [VAL_W-1:0]   r_rdata;
    logic                      r_rd_vld;
    logic [CORNER_W-1:0]       r_rd_idx;

    logic signed [VAL_W-1:0]   r_xa, r_xo, r_ya, r_yo, r_za, r_res, r_out;
    logic                      r_xo_vld, r_yo_vld, r_res_vld, r_out_vld;
    logic [1:0]                r_xo_idx;
    logic                      r_yo_idx;

    logic signed [CW-1:0] fx, fy, fz;
    logic [STORE_AW-1:0]  rd_addr;
    logic [FRAC_BITS-1:0] tx, ty, tz;

    assign fx = CW'(r_cx) >>> FRAC_BITS;
    assign fy = CW'(r_cy) >>> FRAC_BITS;
    assign fz = CW'(r_cz) >>> FRAC_BITS;
    assign tx = r_cx[FRAC_BITS-1:0];
    assign ty = r_cy[FRAC_BITS-1:0];
    assign tz = r_cz[FRAC_BITS-1:0];

    assign rd_addr = (i_cmd.rd_idx[2] ? STORE_AW'(r_z1o) : STORE_AW'(r_z0o))
                   + (i_cmd.rd_idx[1] ? STORE_AW'(r_y1dx) : STORE_AW'(r_y0dx))
                   + (i_cmd.rd_idx[0] ? STORE_AW'(r_x1) : STORE_AW'(r_x0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_RESET;
            r_dim_y <= DIM_RESET;
            r_dim_z <= DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIM_X: r_dim_x <= i_cfg_data;
                CFG_DIM_Y: r_dim_y <= i_cfg_data;
                CFG_DIM_Z: r_dim_z <= i_cfg_data;
                default:   r_dim_x <= r_dim_x;
            endcase
        end
    end

    // setup: floor/clamp, then row offsets, then plane offsets
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
            r_cz <= i_coord_z;
        end
        if (i_cmd.clamp) begin
            r_dx <= f_eff(r_dim_x);
            r_dy <= f_eff(r_dim_y);
            r_x0 <= f_clamp(fx, f_eff(r_dim_x));
            r_x1 <= f_clamp(fx + $signed(CW'(1)), f_eff(r_dim_x));
            r_y0 <= f_clamp(fy, f_eff(r_dim_y));
            r_y1 <= f_clamp(fy + $signed(CW'(1)), f_eff(r_dim_y));
            r_z0 <= f_clamp(fz, f_eff(r_dim_z));
            r_z1 <= f_clamp(fz + $signed(CW'(1)), f_eff(r_dim_z));
        end
        if (i_cmd.row) begin
            r_dxy  <= (2*DW)'(r_dx) * (2*DW)'(r_dy);
            r_y0dx <= RW'(r_y0) * RW'(r_dx);
            r_y1dx <= RW'(r_y1) * RW'(r_dx);
        end
        if (i_cmd.plane) begin
            r_z0o <= PW'(r_z0) * PW'(r_dxy);
            r_z1o <= PW'(r_z1) * PW'(r_dxy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) r_mem[i_voxel_index] <= i_voxel_value;
        if (i_cmd.rd_en) r_rdata <= $signed(r_mem[rd_addr]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_xo_vld  <= 1'b0;
            r_yo_vld  <= 1'b0;
            r_res_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld  <= i_cmd.rd_en;
            r_xo_vld  <= r_rd_vld && r_rd_idx[0];
            r_yo_vld  <= r_xo_vld && r_xo_idx[0];
            r_res_vld <= r_yo_vld && r_yo_idx;
            if (i_cmd.load_out) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    // x lerps on corner pairs, y lerps on x pairs, z lerp last
    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_cmd.rd_idx;
        r_xo_idx <= r_rd_idx[2:1];
        r_yo_idx <= r_xo_idx[1];
        if (r_rd_vld && !r_rd_idx[0]) r_xa <= r_rdata;
        if (r_rd_vld && r_rd_idx[0])  r_xo <= f_lerp(r_xa, r_rdata, tx);
        if (r_xo_vld && !r_xo_idx[0]) r_ya <= r_xo;
        if (r_xo_vld && r_xo_idx[0])  r_yo <= f_lerp(r_ya, r_xo, ty);
        if (r_yo_vld && !r_yo_idx)    r_za <= r_yo;
        if (r_yo_vld && r_yo_idx)     r_res <= f_lerp(r_za, r_yo, tz);
        if (i_cmd.load_out)           r_out <= r_res;
    end

    assign o_sts.done     = r_res_vld;
    assign o_sts.out_full = r_out_vld;
    assign o_out_valid    = r_out_vld;
    assign o_sample_value = r_out;

endmodule

// ===== design/trilinear_voxel_sampler.sv =====
// Top level of the trilinear voxel sampler: sequencer plus datapath.
//
//  channel | direction | handshake                      | payload
//  in      | in        | i_in_valid / o_in_stall        | mode, voxel_index, voxel_value, coord_x/y/z
//  out     | out       | o_out_valid / i_out_stall      | sample_value
//  cfg     | in        | i_cfg_valid / o_cfg_ready      | cfg_index, cfg_data
//
// A store beat is written to the voxel memory without leaving idle. A sample beat runs from
// acceptance to the result register through setup (clamp, row offsets, plane offsets), eight
// corner reads on the voxel memory read port and the lerp stages, then a hand-off state;
// the input stays stalled for a sample until the sequencer is back in idle.
// Synchronous active-low reset clears control and sets all dimensions to 32; voxel
// contents are undefined until written. A held result stalls the next sample only at
// hand-off, and the input stays stalled while it waits there.
module trilinear_voxel_sampler
    import tvs_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_mode,
    input  logic [STORE_AW-1:0]       i_voxel_index,
    input  logic signed [VAL_W-1:0]   i_voxel_value,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VAL_W-1:0]   o_sample_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [DIM_REG_W-1:0]      i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    tvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tvs_dp #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_voxel_index  (i_voxel_index),
        .i_voxel_value  (i_voxel_value),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sample_value (o_sample_value)
    );

    a_sample_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode) |=> o_in_stall)
        else $error("sample beat did not block the input");

    a_load_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !sts.out_full)
        else $error("result loaded over a held result");

    a_no_store_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_en |-> (!cmd.store && o_in_stall))
        else $error("store overlaps corner reads");

endmodule
